>>> hw/rtl/sdq_pkg.sv
// Package with shared types and constants for the sorted delay queue.
package sdq_pkg;

  // Number of cells in the queue.
  localparam int CAPACITY = 32;

  localparam int TIME_W = 31;
  localparam int ID_W   = 8;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_t;

  // Status codes carried in the output tuser field.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Contents of one queue cell.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] wake_time;
    logic [ID_W-1:0]   proc_id;
  } entry_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [TIME_W-1:0] wake_time;
    logic [ID_W-1:0]   proc_id;
  } cell_cmd_t;

endpackage

>>> hw/rtl/sdq_cell.sv
// One cell of the sorted queue: holds an entry, compares it and shifts with its neighbors.
module sdq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sdq_pkg::cell_cmd_t cmd,
  input  sdq_pkg::entry_t    prev_entry,
  input  logic               prev_lt,
  input  sdq_pkg::entry_t    next_entry,
  output sdq_pkg::entry_t    entry,
  output logic               own_lt
);
  import sdq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  // This cell stays ahead of a new entry when it holds an earlier time.
  assign own_lt = valid_r && (time_r < cmd.wake_time);

  assign entry.valid     = valid_r;
  assign entry.wake_time = time_r;
  assign entry.proc_id   = id_r;

  // Insert: keep, take the new entry at the boundary, or take the left neighbor.
  // Remove: take the right neighbor.
  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    id_nxt    = id_r;
    if (cmd.ins) begin
      if (own_lt) begin
        valid_nxt = valid_r;
      end else if (prev_lt) begin
        valid_nxt = 1'b1;
        time_nxt  = cmd.wake_time;
        id_nxt    = cmd.proc_id;
      end else begin
        valid_nxt = prev_entry.valid;
        time_nxt  = prev_entry.wake_time;
        id_nxt    = prev_entry.proc_id;
      end
    end else if (cmd.rem) begin
      valid_nxt = next_entry.valid;
      time_nxt  = next_entry.wake_time;
      id_nxt    = next_entry.proc_id;
    end
  end

  // Occupancy flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset; it is only read while the cell is occupied.
  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    id_r   <= id_nxt;
  end

endmodule

>>> hw/rtl/sorted_delay_queue.sv
// Top level of the sorted delay queue: a row of compare-and-shift cells and a result register.
//
// Keeps up to CAPACITY (32) sleeping entries in ascending wake-time order. A new entry goes
// ahead of any stored entry with the same wake time, so among equal times the newest leaves
// first. For each request (insert, remove earliest, peek earliest) every
// cell compares its time against the new one and shifts in parallel, so a new request is
// taken in every cycle while the result consumer keeps up. The result appears in an output
// register in the cycle after the request is accepted and stays there until taken; the next
// request is accepted in the same cycle that the waiting result is taken. After reset the
// queue is empty and ready at once.
module sorted_delay_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [30:0] wake_time, [38:31] proc_id, [39] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_id, [38:8] out_time, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import sdq_pkg::*;

  entry_t            entries [CAPACITY];
  logic              lt      [CAPACITY];
  cell_cmd_t         cmd;
  op_t               op;
  logic              accept;
  logic              full;
  logic              empty;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  // A request is taken whenever the result register is free or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign full      = entries[CAPACITY-1].valid;
  assign empty     = !entries[0].valid;

  // Command broadcast to all cells.
  always_comb begin
    cmd.ins       = accept && (op == OP_INSERT) && !full;
    cmd.rem       = accept && (op == OP_REMOVE) && !empty;
    cmd.wake_time = in_tdata[TIME_W-1:0];
    cmd.proc_id   = in_tdata[TIME_W+ID_W-1:TIME_W];
  end

  // Row of cells; the head sees an always-earlier left neighbor, the tail an empty right one.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_l;

    if (k == 0) begin : g_head
      assign prev_e = '0;
      assign prev_l = 1'b1;
    end else begin : g_body
      assign prev_e = entries[k-1];
      assign prev_l = lt[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entries[k+1];
    end

    sdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_entry (prev_e),
      .prev_lt    (prev_l),
      .next_entry (next_e),
      .entry      (entries[k]),
      .own_lt     (lt[k])
    );
  end

  // Result for the accepted request.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    id_nxt        = id_r;
    time_nxt      = time_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STATUS_OK;
      id_nxt        = '0;
      time_nxt      = '0;
      unique case (op)
        OP_INSERT: begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            id_nxt   = entries[0].proc_id;
            time_nxt = entries[0].wake_time;
          end
        end
        OP_PEEK: begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            time_nxt = entries[0].wake_time;
          end
        end
        default: begin
          status_nxt = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    id_r     <= id_nxt;
    time_r   <= time_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, time_r, id_r};

endmodule

>>> hw/rtl/sdq_checker.sv
// Port-level checker for the sorted delay queue, bound to the top level.
module sdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import sdq_pkg::*;

  // Every accepted request yields a result in the next cycle.
  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

  // A free result register never blocks the input.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while no result waits");

  // A failed request carries no id and no time.
  a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_FULL || out_tuser == STATUS_EMPTY)
      |-> out_tdata == '0)
    else $error("failed request returned data");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind sorted_delay_queue sdq_checker u_sdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/sorted_delay_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted delay queue: directed table, then random traffic.
module sorted_delay_queue_test;
  import sdq_pkg::*;

  // Op code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int DIRECTED_ROWS = 25;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int BURST_LEN = 50;
  localparam int PHASES = 4;
  localparam int MAX_PRINTS = 40;
  localparam int SEND_IDLE [PHASES] = '{0, 48, 0, 22};
  localparam int RECV_STALL [PHASES] = '{0, 0, 48, 22};

  // Traffic shapes of the random part.
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] wake_time;
  } wake_result_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] wake_time;
    logic [ID_W-1:0]   proc_id;
    logic              pinned;
    wake_result_t      result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [30:0] wake_time, [38:31] proc_id, [39] zero
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [7:0] out_id, [38:8] out_time, [39] zero
  logic [1:0]  out_tuser;       // [1:0] status

  // Shadow copy of the sleeping entries, head at index zero.
  logic [TIME_W-1:0] sleep_time [CAPACITY];
  logic [ID_W-1:0]   sleep_id [CAPACITY];
  int                sleep_count = 0;

  wake_result_t pending_results [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Directed requests; rows with pinned set carry a result that is obvious by inspection.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_PEEK,   31'd0,    8'h00, 1'b1, '{STATUS_EMPTY, 8'h00, 31'd0}},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b1, '{STATUS_EMPTY, 8'h00, 31'd0}},
    '{OP_UNUSED, TIME_MAX, 8'hff, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_INSERT, TIME_MAX, 8'hff, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_PEEK,   31'd0,    8'h00, 1'b1, '{STATUS_OK,    8'h00, TIME_MAX}},
    '{OP_INSERT, 31'd0,    8'h00, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_PEEK,   TIME_MAX, 8'hff, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_INSERT, 31'd0,    8'h55, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b1, '{STATUS_OK,    8'h55, 31'd0}},
    '{OP_REMOVE, TIME_MAX, 8'haa, 1'b1, '{STATUS_OK,    8'h00, 31'd0}},
    '{OP_INSERT, 31'd100,  8'h01, 1'b0, '0},
    '{OP_INSERT, 31'd100,  8'h02, 1'b0, '0},
    '{OP_INSERT, 31'd50,   8'h03, 1'b0, '0},
    '{OP_INSERT, 31'd200,  8'h04, 1'b0, '0},
    '{OP_INSERT, 31'd100,  8'h05, 1'b0, '0},
    '{OP_UNUSED, 31'd1,    8'h06, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_PEEK,   31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b0, '0},
    '{OP_REMOVE, 31'd0,    8'h00, 1'b1, '{STATUS_EMPTY, 8'h00, 31'd0}},
    '{OP_PEEK,   TIME_MAX, 8'hff, 1'b1, '{STATUS_EMPTY, 8'h00, 31'd0}}
  };

  sorted_delay_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow queue and returns the result it should produce.
  function automatic wake_result_t predict_wake_queue(input logic [1:0] op,
                                                      input logic [TIME_W-1:0] t,
                                                      input logic [ID_W-1:0] id);
    wake_result_t res;
    int pos;
    int k;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_INSERT: begin
        if (sleep_count == CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // New entry goes ahead of every entry with an equal or later time.
          pos = 0;
          while (pos < sleep_count && sleep_time[pos] < t) pos++;
          for (k = sleep_count; k > pos; k--) begin
            sleep_time[k] = sleep_time[k-1];
            sleep_id[k] = sleep_id[k-1];
          end
          sleep_time[pos] = t;
          sleep_id[pos] = id;
          sleep_count++;
        end
      end
      OP_REMOVE: begin
        if (sleep_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.proc_id = sleep_id[0];
          res.wake_time = sleep_time[0];
          for (k = 0; k + 1 < sleep_count; k++) begin
            sleep_time[k] = sleep_time[k+1];
            sleep_id[k] = sleep_id[k+1];
          end
          sleep_count--;
        end
      end
      OP_PEEK: begin
        if (sleep_count == 0) res.status = STATUS_EMPTY;
        else res.wake_time = sleep_time[0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, wanted, $realtime);
  endtask

  // Presents one request, waits for the handshake, and records its expected result.
  task automatic send_request(input logic [1:0] op, input logic [TIME_W-1:0] t,
                              input logic [ID_W-1:0] id, input logic pinned,
                              input wake_result_t pinned_result);
    wake_result_t predicted;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, id, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_wake_queue(op, t, id);
    pending_results.push_back(pinned ? pinned_result : predicted);
  endtask

  // One random request; the mode tilts the mix toward filling or draining the queue.
  task automatic send_random(input int mode);
    logic [1:0]        op;
    logic [TIME_W-1:0] t;
    int                pick;
    pick = $urandom_range(99);
    case (mode)
      MODE_FILL:  op = (pick < 85) ? OP_INSERT : (pick < 95) ? OP_REMOVE : OP_PEEK;
      MODE_DRAIN: op = (pick < 15) ? OP_INSERT : (pick < 85) ? OP_REMOVE : OP_PEEK;
      default:    op = (pick < 45) ? OP_INSERT : (pick < 80) ? OP_REMOVE : OP_PEEK;
    endcase
    // Small times make ties common; the full range toggles every bit.
    case ($urandom_range(9))
      0: t = '0;
      1: t = TIME_MAX;
      2, 3, 4: t = TIME_W'($urandom_range(15));
      default: t = TIME_W'($urandom());
    endcase
    send_request(op, t, ID_W'($urandom_range(255)), 1'b0, '0);
  endtask

  // Result consumer backpressure.
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin : result_check
    wake_result_t seen;
    wake_result_t wanted;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = out_tuser;
      seen.proc_id = out_tdata[7:0];
      seen.wake_time = out_tdata[38:8];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(seen), 64'd0);
      end else begin
        wanted = pending_results.pop_front();
        if (seen.status !== wanted.status)
          report_mismatch("status", 64'(seen.status), 64'(wanted.status));
        if (seen.proc_id !== wanted.proc_id)
          report_mismatch("out_id", 64'(seen.proc_id), 64'(wanted.proc_id));
        if (seen.wake_time !== wanted.wake_time)
          report_mismatch("out_time", 64'(seen.wake_time), 64'(wanted.wake_time));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : stimulus
    int phase;
    int n;
    int mode;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_request(directed_rows[n].op, directed_rows[n].wake_time, directed_rows[n].proc_id,
                   directed_rows[n].pinned, directed_rows[n].result);
    end
    mode = MODE_MIXED;
    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BURST_LEN == 0) mode = $urandom_range(2);
        send_random(mode);
      end
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_cell.sv
hw/rtl/sorted_delay_queue.sv
hw/rtl/sdq_checker.sv
test/sorted_delay_queue_test.sv
